### hdl/ecdrbg_pkg.sv
// Shared types and constants for the dual EC random generator.
package ecdrbg_pkg;

	localparam int unsigned CFG_BITS  = 8;
	localparam int unsigned CFG_IDX_BITS = 3;

	localparam logic [CFG_IDX_BITS-1:0] REG_FIELD_PRIME = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_CURVE_A     = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_BASE_X      = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_BASE_Y      = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_OUT_X       = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_OUT_Y       = 3'd5;

	localparam logic [CFG_BITS-1:0] RST_FIELD_PRIME = 8'd233;
	localparam logic [CFG_BITS-1:0] RST_CURVE_A     = 8'd1;
	localparam logic [CFG_BITS-1:0] RST_BASE_X      = 8'd3;
	localparam logic [CFG_BITS-1:0] RST_BASE_Y      = 8'd65;
	localparam logic [CFG_BITS-1:0] RST_OUT_X       = 8'd83;
	localparam logic [CFG_BITS-1:0] RST_OUT_Y       = 8'd97;

	typedef struct packed {
		logic signed [63:0] seed;
		logic [6:0]         block_count;
	} req_t;

	typedef struct packed {
		logic [7:0] random_value;
		logic       last;
	} rsp_t;

	// datapath operations
	localparam logic [3:0] OP_NONE   = 4'd0;
	localparam logic [3:0] OP_REDUCE = 4'd1;
	localparam logic [3:0] OP_MUL    = 4'd2;
	localparam logic [3:0] OP_INV    = 4'd3;

	typedef struct packed {
		logic       start;
		logic [3:0] op;
	} dp_cmd_t;

	typedef struct packed {
		logic done;
		logic ok;
	} dp_sts_t;

endpackage

### hdl/ecdrbg_arith.sv
// Modular arithmetic unit: serial reduce, shift-add multiply, Euclid inverse.
module ecdrbg_arith (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ecdrbg_pkg::dp_cmd_t     cmd,
	input  logic [7:0]              opa,
	input  logic [7:0]              opb,
	input  logic [7:0]              modulus,
	output ecdrbg_pkg::dp_sts_t     sts,
	output logic [7:0]              result
);
	import ecdrbg_pkg::*;

	localparam logic [1:0] A_IDLE = 2'd0;
	localparam logic [1:0] A_MUL  = 2'd1;
	localparam logic [1:0] A_INV  = 2'd2;
	localparam logic [1:0] A_DIV  = 2'd3;

	logic [1:0]  st_q;
	logic [3:0]  cnt_q;
	logic [7:0]  acc_q, ma_q, mb_q;
	logic [7:0]  dvd_q, dvs_q, quo_q;
	logic [7:0]  r_q, nr_q;
	logic [8:0]  t_q, nt_q;
	logic        euclid_q;
	logic        done_q, ok_q;
	logic [7:0]  res_q;
	logic [8:0]  m9, dbl, dbl_r, msum, shl, ntn, t_pos;
	logic [7:0]  mul_nxt, rem_nxt, quo_nxt, fin_res;
	logic [17:0] prodw;
	logic        sub_ok, mul_fin, div_fin, inv_fin, fin, fin_ok;

	assign m9 = {1'b0, modulus};
	assign sts.done = done_q;
	assign sts.ok   = ok_q;
	assign result   = res_q;

	always_comb begin
		dbl     = {acc_q, 1'b0};
		dbl_r   = (dbl >= m9) ? dbl - m9 : dbl;
		msum    = dbl_r + (mb_q[7] ? {1'b0, ma_q} : 9'd0);
		mul_nxt = (msum >= m9) ? 8'(msum - m9) : msum[7:0];
		shl     = {acc_q, dvd_q[7]};
		sub_ok  = (shl >= {1'b0, dvs_q});
		rem_nxt = sub_ok ? 8'(shl - {1'b0, dvs_q}) : shl[7:0];
		quo_nxt = {quo_q[6:0], sub_ok};
		prodw   = {10'd0, quo_nxt} * {9'd0, nt_q};
		ntn     = t_q - prodw[8:0];
		t_pos   = t_q[8] ? t_q + m9 : t_q;
		mul_fin = (st_q == A_MUL) && (cnt_q == 4'd1);
		div_fin = (st_q == A_DIV) && (cnt_q == 4'd1) && !euclid_q;
		inv_fin = (st_q == A_INV) && (nr_q == 8'd0);
		fin     = mul_fin || div_fin || inv_fin;
		fin_ok  = !inv_fin || (r_q == 8'd1);
		fin_res = mul_fin ? mul_nxt : (div_fin ? rem_nxt : t_pos[7:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= A_IDLE;
			done_q <= 1'b0;
			ok_q   <= 1'b0;
			res_q  <= '0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin;
			if (fin) begin
				ok_q  <= fin_ok;
				res_q <= fin_res;
			end
			unique case (st_q)
				A_IDLE: begin
					if (cmd.start) begin
						unique case (cmd.op)
							OP_REDUCE: begin
								acc_q    <= '0;
								dvd_q    <= opa;
								dvs_q    <= modulus;
								quo_q    <= '0;
								cnt_q    <= 4'd8;
								euclid_q <= 1'b0;
								st_q     <= A_DIV;
							end
							OP_MUL: begin
								acc_q <= '0;
								ma_q  <= opa;
								mb_q  <= opb;
								cnt_q <= 4'd8;
								st_q  <= A_MUL;
							end
							OP_INV: begin
								r_q  <= modulus;
								nr_q <= opa;
								t_q  <= '0;
								nt_q <= 9'd1;
								st_q <= A_INV;
							end
							default: ;
						endcase
					end
				end
				A_MUL: begin
					acc_q <= mul_nxt;
					mb_q  <= {mb_q[6:0], 1'b0};
					cnt_q <= cnt_q - 4'd1;
					if (cnt_q == 4'd1) st_q <= A_IDLE;
				end
				A_DIV: begin
					acc_q <= rem_nxt;
					dvd_q <= {dvd_q[6:0], 1'b0};
					quo_q <= quo_nxt;
					cnt_q <= cnt_q - 4'd1;
					if (cnt_q == 4'd1) begin
						if (euclid_q) begin
							// advance the Euclid state by one quotient
							r_q  <= nr_q;
							nr_q <= rem_nxt;
							t_q  <= nt_q;
							nt_q <= ntn;
							st_q <= A_INV;
						end else begin
							st_q <= A_IDLE;
						end
					end
				end
				A_INV: begin
					if (nr_q == 8'd0) begin
						st_q <= A_IDLE;
					end else begin
						acc_q    <= '0;
						dvd_q    <= r_q;
						dvs_q    <= nr_q;
						quo_q    <= '0;
						cnt_q    <= 4'd8;
						euclid_q <= 1'b1;
						st_q     <= A_DIV;
					end
				end
				default: st_q <= A_IDLE;
			endcase
		end
	end
endmodule

### hdl/ecdrbg_ctrl.sv
// Sequencer for the scalar multiplies, point adds and block loop.
module ecdrbg_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ecdrbg_pkg::req_t    in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output ecdrbg_pkg::rsp_t    out_data,
	input  logic [7:0]          cfg_p,
	input  logic [7:0]          cfg_a,
	input  logic [7:0]          cfg_gx,
	input  logic [7:0]          cfg_gy,
	input  logic [7:0]          cfg_qx,
	input  logic [7:0]          cfg_qy,
	output ecdrbg_pkg::dp_cmd_t cmd,
	output logic [7:0]          opa,
	output logic [7:0]          opb,
	input  ecdrbg_pkg::dp_sts_t sts,
	input  logic [7:0]          result
);
	import ecdrbg_pkg::*;

	localparam logic [5:0] S_IDLE = 6'd0;
	localparam logic [5:0] S_RED  = 6'd1;
	localparam logic [5:0] S_BLK  = 6'd2;
	localparam logic [5:0] S_BIT  = 6'd3;
	localparam logic [5:0] S_ADD  = 6'd4;
	localparam logic [5:0] S_OP   = 6'd5;
	localparam logic [5:0] S_WAIT = 6'd6;
	localparam logic [5:0] S_DBL  = 6'd7;
	localparam logic [5:0] S_END  = 6'd8;
	localparam logic [5:0] S_OUT  = 6'd9;
	localparam logic [5:0] S_FIN  = 6'd10;

	logic [5:0]  st_q;
	logic [63:0] k_q, s_q;
	logic [6:0]  n_q, i_q;
	logic [7:0]  a_q, gx_q, gy_q, qx_q, qy_q;
	logic [2:0]  red_q;
	logic        phase_q;
	logic [7:0]  px_q, py_q, ax_q, ay_q;
	logic        pinf_q, ainf_q;
	logic        dbl_q;
	logic [7:0]  ux, uy, vx, vy;
	logic        uinf, vinf;
	logic [3:0]  step_q;
	logic [7:0]  sl_q, t_q, x3_q, rv_q;
	logic [7:0]  m;
	logic        ovalid_q;
	rsp_t        odata_q;
	logic        started_q;

	assign m = cfg_p;
	assign in_ready  = (st_q == S_IDLE) && !ovalid_q;
	assign out_valid = ovalid_q;
	assign out_data  = odata_q;

	function automatic logic [7:0] madd(input logic [7:0] x, input logic [7:0] y,
			input logic [7:0] md);
		logic [8:0] s;
		s = {1'b0, x} + {1'b0, y};
		return (s >= {1'b0, md}) ? 8'(s - {1'b0, md}) : s[7:0];
	endfunction

	function automatic logic [7:0] msub(input logic [7:0] x, input logic [7:0] y,
			input logic [7:0] md);
		return (x >= y) ? x - y : 8'({1'b0, x} + {1'b0, md} - {1'b0, y});
	endfunction

	always_comb begin
		ux = dbl_q ? px_q : ax_q;
		uy = dbl_q ? py_q : ay_q;
		uinf = dbl_q ? pinf_q : ainf_q;
		vx = px_q;
		vy = py_q;
		vinf = pinf_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_IDLE;
			ovalid_q  <= 1'b0;
			cmd       <= '0;
			started_q <= 1'b0;
		end else begin
			if (ovalid_q && out_ready) ovalid_q <= 1'b0;
			unique case (st_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						s_q  <= in_data.seed[63] ? '0 : in_data.seed;
						n_q  <= (in_data.block_count > 7'd64) ? 7'd64 : in_data.block_count;
						i_q  <= '0;
						red_q <= '0;
						started_q <= 1'b0;
						st_q <= (in_data.block_count == '0) ? S_IDLE : S_RED;
					end
				end
				S_RED: begin
					// reduce each config value but p itself mod p; a modulus below 2 gives a zero value
					if (m < 8'd2) begin
						rv_q <= '0;
						st_q <= S_OUT;
					end else if (!started_q) begin
						unique case (red_q)
							3'd0: opa <= cfg_a;
							3'd1: opa <= cfg_gx;
							3'd2: opa <= cfg_gy;
							3'd3: opa <= cfg_qx;
							default: opa <= cfg_qy;
						endcase
						cmd <= '{start: 1'b1, op: OP_REDUCE};
						started_q <= 1'b1;
					end else begin
						cmd.start <= 1'b0;
						if (sts.done) begin
							started_q <= 1'b0;
							unique case (red_q)
								3'd0: a_q  <= result;
								3'd1: gx_q <= result;
								3'd2: gy_q <= result;
								3'd3: qx_q <= result;
								default: qy_q <= result;
							endcase
							red_q <= red_q + 3'd1;
							if (red_q == 3'd4) begin
								phase_q <= 1'b0;
								st_q <= S_BLK;
							end
						end
					end
				end
				S_BLK: begin
					k_q <= s_q;
					px_q <= phase_q ? qx_q : gx_q;
					py_q <= phase_q ? qy_q : gy_q;
					pinf_q <= 1'b0;
					ainf_q <= 1'b1;
					st_q <= S_BIT;
				end
				S_BIT: begin
					if (k_q == '0) begin
						st_q <= S_END;
					end else begin
						dbl_q <= !k_q[0];
						st_q  <= k_q[0] ? S_ADD : S_DBL;
					end
				end
				S_DBL: begin
					dbl_q <= 1'b1;
					st_q  <= S_ADD;
				end
				S_ADD: begin
					// special cases of the point add
					if (uinf) begin
						if (!dbl_q) begin
							ax_q <= vx; ay_q <= vy; ainf_q <= vinf;
						end
						st_q <= dbl_q ? S_FIN : S_DBL;
					end else if (vinf) begin
						st_q <= dbl_q ? S_FIN : S_DBL;
					end else if (ux == vx && madd(uy, vy, m) == 8'd0) begin
						if (dbl_q) pinf_q <= 1'b1; else ainf_q <= 1'b1;
						st_q <= dbl_q ? S_FIN : S_DBL;
					end else begin
						step_q <= '0;
						st_q <= S_OP;
					end
				end
				S_OP: begin
					// step through slope, inverse and result products
					unique case (step_q)
						4'd0: begin
							if (ux != vx || uy != vy) begin
								t_q  <= msub(vy, uy, m);
								opa  <= msub(vx, ux, m);
								cmd  <= '{start: 1'b1, op: OP_INV};
								step_q <= 4'd3;
							end else begin
								opa <= ux; opb <= ux;
								cmd <= '{start: 1'b1, op: OP_MUL};
								step_q <= 4'd0;
							end
							st_q <= S_WAIT;
						end
						4'd1: begin
							t_q <= madd(madd(madd(sl_q, sl_q, m), sl_q, m), a_q, m);
							opa <= madd(uy, uy, m);
							cmd <= '{start: 1'b1, op: OP_INV};
							step_q <= 4'd3;
							st_q <= S_WAIT;
						end
						4'd4: begin
							opa <= t_q; opb <= sl_q;
							cmd <= '{start: 1'b1, op: OP_MUL};
							step_q <= 4'd5;
							st_q <= S_WAIT;
						end
						4'd6: begin
							opa <= sl_q; opb <= sl_q;
							cmd <= '{start: 1'b1, op: OP_MUL};
							t_q <= sl_q;
							step_q <= 4'd7;
							st_q <= S_WAIT;
						end
						4'd8: begin
							x3_q <= msub(msub(sl_q, ux, m), vx, m);
							opa <= t_q;
							opb <= msub(ux, msub(msub(sl_q, ux, m), vx, m), m);
							cmd <= '{start: 1'b1, op: OP_MUL};
							step_q <= 4'd9;
							st_q <= S_WAIT;
						end
						default: begin
							if (dbl_q) begin
								px_q <= x3_q; py_q <= msub(sl_q, uy, m);
							end else begin
								ax_q <= x3_q; ay_q <= msub(sl_q, uy, m);
							end
							st_q <= dbl_q ? S_FIN : S_DBL;
						end
					endcase
				end
				S_WAIT: begin
					cmd.start <= 1'b0;
					if (sts.done) begin
						sl_q <= result;
						if (!sts.ok) begin
							if (dbl_q) pinf_q <= 1'b1; else ainf_q <= 1'b1;
							st_q <= dbl_q ? S_FIN : S_DBL;
						end else begin
							step_q <= step_q + 4'd1;
							st_q <= S_OP;
						end
					end
				end
				S_FIN: begin
					k_q  <= {1'b0, k_q[63:1]};
					st_q <= S_BIT;
				end
				S_END: begin
					if (!phase_q) begin
						s_q <= ainf_q ? 64'd0 : {56'd0, ax_q};
						phase_q <= 1'b1;
						st_q <= S_BLK;
					end else begin
						rv_q <= ainf_q ? 8'd0 : ax_q;
						st_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!ovalid_q) begin
						ovalid_q <= 1'b1;
						odata_q <= '{random_value: rv_q, last: (i_q + 7'd1 == n_q)};
						i_q <= i_q + 7'd1;
						phase_q <= 1'b0;
						if (i_q + 7'd1 == n_q) st_q <= S_IDLE;
						else if (m < 8'd2) st_q <= S_RED;
						else st_q <= S_BLK;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

### hdl/ec_dual_drbg_generator.sv
// Top level of the dual EC random generator.
//  channel | signals                        | role
//  in      | in_valid in_ready in_data      | seed and block count request
//  out     | out_valid out_ready out_data   | one random value per block
//  cfg     | cfg_we cfg_index cfg_data      | register writes
// Each block runs two scalar multiplies, one or two point operations per scalar bit;
// a modulus below 2 skips them and gives zero. A point add or double is mostly the
// Euclid inverse, a series of serial divide steps, plus shift-add modular multiplies.
// Reset restores the register defaults; a request is taken only when idle
// with no result waiting, and the sequencer holds before emitting a value
// while the previous result still waits.
module ec_dual_drbg_generator (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ecdrbg_pkg::req_t    in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output ecdrbg_pkg::rsp_t    out_data,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [7:0]          cfg_data
);
	import ecdrbg_pkg::*;

	logic [7:0] p_q, a_q, gx_q, gy_q, qx_q, qy_q;
	dp_cmd_t    cmd;
	dp_sts_t    sts;
	logic [7:0] opa, opb, result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q  <= RST_FIELD_PRIME;
			a_q  <= RST_CURVE_A;
			gx_q <= RST_BASE_X;
			gy_q <= RST_BASE_Y;
			qx_q <= RST_OUT_X;
			qy_q <= RST_OUT_Y;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FIELD_PRIME: p_q  <= cfg_data;
				REG_CURVE_A:     a_q  <= cfg_data;
				REG_BASE_X:      gx_q <= cfg_data;
				REG_BASE_Y:      gy_q <= cfg_data;
				REG_OUT_X:       qx_q <= cfg_data;
				REG_OUT_Y:       qy_q <= cfg_data;
				default: ;
			endcase
		end
	end

	ecdrbg_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_p(p_q), .cfg_a(a_q), .cfg_gx(gx_q), .cfg_gy(gy_q),
		.cfg_qx(qx_q), .cfg_qy(qy_q),
		.cmd(cmd), .opa(opa), .opb(opb), .sts(sts), .result(result)
	);

	ecdrbg_arith u_arith (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .opa(opa), .opb(opb),
		.modulus(p_q), .sts(sts), .result(result)
	);
endmodule

### bench/tb_ec_dual_drbg_generator.sv
// Self-checking testbench for the dual EC random generator: directed table, then random requests.
`timescale 1ns / 1ps
module tb_ec_dual_drbg_generator;
	import ecdrbg_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000000;
	localparam int DRAIN_CYCLES   = 1000;
	localparam int MAX_BLOCKS     = 64;

	typedef struct {
		longint x;
		longint y;
		bit     inf;
	} ec_point_t;

	typedef struct {
		logic signed [63:0] seed;
		logic [6:0]         count;
		bit                 all_zero;
	} seed_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	req_t       in_data = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	rsp_t       out_data;
	logic       cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;

	longint prime_q, coef_a, gen_x, gen_y, outpt_x, outpt_y;
	rsp_t   value_q[$];
	int     mismatches = 0;
	int     idle_cycles = 0;
	int     tx_idle_pct = 37;
	int     rx_idle_pct = 75;

	seed_row_t seed_table[12] = '{
		'{64'sd0, 7'd1, 1'b1},
		'{-64'sd1, 7'd2, 1'b1},
		'{64'sh8000_0000_0000_0000, 7'd1, 1'b1},
		'{64'sd5, 7'd0, 1'b0},
		'{64'sh7fff_ffff_ffff_ffff, 7'd1, 1'b0},
		'{64'sd1, 7'd1, 1'b0},
		'{64'sd2, 7'd3, 1'b0},
		'{64'sd7, 7'd2, 1'b0},
		'{64'sh5555_5555_5555_5555, 7'd1, 1'b0},
		'{64'sh2aaa_aaaa_aaaa_aaaa, 7'd1, 1'b0},
		'{64'sd123, 7'd64, 1'b0},
		'{64'sd99, 7'd127, 1'b0}
	};

	ec_dual_drbg_generator u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic bit mod_inverse(longint v, longint m, output longint res);
		longint t, nt, r, nr, q, tmp;
		t = 0; nt = 1; r = m; nr = v;
		while (nr != 0) begin
			q = r / nr;
			tmp = nt; nt = t - q * nt; t = tmp;
			tmp = nr; nr = r - q * nr; r = tmp;
		end
		if (r != 1)
			return 1'b0;
		if (t < 0)
			t += m;
		res = t;
		return 1'b1;
	endfunction

	function automatic ec_point_t ec_add(ec_point_t u, ec_point_t v, longint m, longint a);
		ec_point_t sum;
		longint num, den, iv, sl;
		sum = '{0, 0, 1'b1};
		if (u.inf)
			return v;
		if (v.inf)
			return u;
		if (u.x == v.x && (u.y + v.y) % m == 0)
			return sum;
		if (u.x != v.x || u.y != v.y) begin
			num = (v.y + m - u.y) % m;
			den = (v.x + m - u.x) % m;
		end else begin
			num = (3 * ((u.x * u.x) % m) + a) % m;
			den = (2 * u.y) % m;
		end
		if (!mod_inverse(den, m, iv))
			return sum;
		sl = (num * iv) % m;
		sum.x = ((sl * sl) % m + 2 * m - u.x - v.x) % m;
		sum.y = ((sl * ((u.x + m - sum.x) % m)) % m + m - u.y) % m;
		sum.inf = 1'b0;
		return sum;
	endfunction

	function automatic ec_point_t scalar_mul(bit [63:0] k, ec_point_t pt, longint m, longint a);
		ec_point_t acc;
		acc = '{0, 0, 1'b1};
		while (k != 0) begin
			if (k[0])
				acc = ec_add(acc, pt, m, a);
			pt = ec_add(pt, pt, m, a);
			k >>= 1;
		end
		return acc;
	endfunction

	task automatic predict_values(req_t req);
		int        n;
		bit [63:0] s;
		longint    a;
		ec_point_t g, q, sp, rp;
		rsp_t      r;
		n = (req.block_count > MAX_BLOCKS) ? MAX_BLOCKS : req.block_count;
		s = req.seed[63] ? 64'd0 : req.seed;
		if (prime_q >= 2) begin
			a = coef_a % prime_q;
			g = '{gen_x % prime_q, gen_y % prime_q, 1'b0};
			q = '{outpt_x % prime_q, outpt_y % prime_q, 1'b0};
		end
		for (int i = 0; i < n; i++) begin
			r.random_value = '0;
			if (prime_q >= 2) begin
				sp = scalar_mul(s, g, prime_q, a);
				s = sp.inf ? 64'd0 : sp.x;
				rp = scalar_mul(s, q, prime_q, a);
				r.random_value = rp.inf ? 8'd0 : rp.x[7:0];
			end
			r.last = (i + 1 == n);
			value_q.push_back(r);
		end
	endtask

	task automatic write_reg(logic [2:0] idx, logic [7:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_FIELD_PRIME: prime_q = val;
			REG_CURVE_A:     coef_a = val;
			REG_BASE_X:      gen_x = val;
			REG_BASE_Y:      gen_y = val;
			REG_OUT_X:       outpt_x = val;
			REG_OUT_Y:       outpt_y = val;
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		wait (value_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_curve(logic [7:0] p, logic [7:0] a, logic [7:0] gx, logic [7:0] gy,
			logic [7:0] qx, logic [7:0] qy);
		wait_drained();
		write_reg(REG_FIELD_PRIME, p);
		write_reg(REG_CURVE_A, a);
		write_reg(REG_BASE_X, gx);
		write_reg(REG_BASE_Y, gy);
		write_reg(REG_OUT_X, qx);
		write_reg(REG_OUT_Y, qy);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_request(req_t req, bit typed_zero);
		bit taken;
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= req;
		do begin
			@(negedge clk);
			taken = in_ready;
			@(posedge clk);
		end while (!taken);
		if (typed_zero) begin
			for (int i = 0; i < req.block_count; i++)
				value_q.push_back('{random_value: 8'd0, last: (i + 1 == req.block_count)});
		end else begin
			predict_values(req);
		end
	endtask

	function automatic logic [6:0] random_count();
		int pick;
		pick = $urandom_range(99);
		if (pick < 40)
			return 7'd1;
		if (pick < 60)
			return 7'd0;
		if (pick < 90)
			return 7'($urandom_range(3, 2));
		return 7'($urandom_range(8, 4));
	endfunction

	task automatic random_requests(int num);
		req_t req;
		for (int i = 0; i < num; i++) begin
			req.seed = {$urandom, $urandom};
			if ($urandom_range(3) == 0)
				req.seed = 64'($urandom_range(300));
			req.block_count = random_count();
			send_request(req, 1'b0);
		end
	endtask

	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= rx_idle_pct);

	always @(negedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("ec_dual_drbg_generator test failed");
				$finish;
			end
			if (out_valid && out_ready) begin
				if (value_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected value %0d last %0b", out_data.random_value,
							out_data.last);
				end else begin
					want = value_q.pop_front();
					if (want.random_value !== out_data.random_value ||
							want.last !== out_data.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %0d last %0b, got %0d last %0b",
								want.random_value, want.last, out_data.random_value,
								out_data.last);
					end
				end
			end
		end
	end

	initial begin
		prime_q = RST_FIELD_PRIME;
		coef_a = RST_CURVE_A;
		gen_x = RST_BASE_X;
		gen_y = RST_BASE_Y;
		outpt_x = RST_OUT_X;
		outpt_y = RST_OUT_Y;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (seed_table[i])
			send_request('{seed: seed_table[i].seed, block_count: seed_table[i].count},
				seed_table[i].all_zero);
		random_requests(15);
		wait_drained();
		random_requests(10);

		tx_idle_pct = 75;
		rx_idle_pct = 37;
		load_curve(8'd5, 8'd0, 8'd1, 8'd2, 8'd4, 8'd3);
		random_requests(12);
		load_curve(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
		random_requests(8);
		load_curve(8'd0, 8'd7, 8'd3, 8'd65, 8'd83, 8'd97);
		send_request('{seed: 64'sd42, block_count: 7'd3}, 1'b1);
		random_requests(4);

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		load_curve(8'd1, 8'd1, 8'd3, 8'd65, 8'd83, 8'd97);
		random_requests(4);
		load_curve(8'd251, 8'd254, 8'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom));
		random_requests(15);
		load_curve(8'd233, 8'd1, 8'd3, 8'd65, 8'd83, 8'd97);
		random_requests(15);

		wait_drained();
		if (mismatches == 0 && value_q.size() == 0)
			$display("ec_dual_drbg_generator test passed");
		else
			$display("ec_dual_drbg_generator test failed");
		$finish;
	end

endmodule

### sim.f
hdl/ecdrbg_pkg.sv
hdl/ecdrbg_arith.sv
hdl/ecdrbg_ctrl.sv
hdl/ec_dual_drbg_generator.sv
bench/tb_ec_dual_drbg_generator.sv
